// ===== hdl/mkf_pkg.sv =====
// ----------------------------------------------------------------------------
// mkf_pkg: shared types and constants of the 3x3 multi-kernel filter
// Register indexes, reset values and the request passed from the front end
// (line stores and window) to the back end (kernel arithmetic).
// ----------------------------------------------------------------------------
package mkf_pkg;

  localparam int MaxColsDefault = 2048;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] REG_FRAME_ROWS = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_FRAME_COLS = 1'd1;

  localparam logic [11:0] FRAME_ROWS_RESET = 12'd480;
  localparam logic [11:0] FRAME_COLS_RESET = 12'd640;

  // One 3x3 window, row-major: top row first, left column first.
  typedef struct packed {
    logic [8:0][7:0] pix;
    logic            last;
  } win_req_t;

  // One finished result.
  typedef struct packed {
    logic [7:0] box_value;
    logic [7:0] sobel_value;
    logic [7:0] unsharp_value;
    logic [7:0] highpass_value;
    logic [7:0] lowpass_value;
    logic       last;
  } res_t;

endpackage

// ===== hdl/mkf_ram.sv =====
// ----------------------------------------------------------------------------
// mkf_ram: generic single-port-write, one-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mkf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/mkf_front.sv =====
// ----------------------------------------------------------------------------
// mkf_front: position counters, line stores and window columns
// Accepts pixels, reads the two stored rows and issues one window request
// per pixel that completes a 3x3 window.
// ----------------------------------------------------------------------------
module mkf_front #(
  parameter int MAX_COLS = mkf_pkg::MaxColsDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [7:0]          pixel,
  input  logic [11:0]         frame_rows,
  input  logic [11:0]         frame_cols,
  input  logic                stall,
  output logic                busy,
  output logic                req_valid,
  output mkf_pkg::win_req_t   req
);

  localparam int AW = $clog2(MAX_COLS);
  localparam int CW = (AW + 1 > 12) ? AW + 1 : 12;

  logic [11:0]   row_r, row_nxt;
  logic [10:0]   col_r, col_nxt;
  logic [CW-1:0] rows_eff, cols_eff;
  logic [AW-1:0] addr;
  logic          row_end, frame_end, produce;

  // Stage 1 registers: pixel and flags wait for the line store read.
  logic          s1_v_r;
  logic [7:0]    s1_pix_r;
  logic [AW-1:0] s1_addr_r;
  logic          s1_prod_r, s1_last_r;
  logic [7:0]    old_q, new_q;

  // Line store read data after the same-column bypass.
  logic [7:0]    old_c, new_c;
  logic          byp_r;
  logic [7:0]    byp_old_r, byp_new_r;

  logic [5:0][7:0] wc_r;
  logic            out_v_r;
  mkf_pkg::win_req_t out_r;

  // Effective frame size: zero acts as one, columns limited to the store depth.
  always_comb begin
    rows_eff = (frame_rows == 12'd0) ? CW'(1) : CW'(frame_rows);
    cols_eff = (frame_cols == 12'd0) ? CW'(1) : CW'(frame_cols);
    if (cols_eff > CW'(MAX_COLS)) begin
      cols_eff = CW'(MAX_COLS);
    end
    addr      = AW'(col_r);
    row_end   = (CW'(col_r) + CW'(1)) >= cols_eff;
    frame_end = row_end && ((CW'(row_r) + CW'(1)) >= rows_eff);
    produce   = (row_r >= 12'd2) && (col_r >= 11'd2);
    row_nxt   = row_r;
    col_nxt   = col_r;
    if (frame_end) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (row_end) begin
      row_nxt = row_r + 12'd1;
      col_nxt = '0;
    end else begin
      col_nxt = col_r + 11'd1;
    end
  end

  // Position counters advance on every accepted pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (push) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // Line stores: read the column in stage 0, write it back in stage 1.
  mkf_ram #(.WIDTH(8), .DEPTH(MAX_COLS)) u_older (
    .clk(clk), .we(s1_v_r), .waddr(s1_addr_r), .wdata(new_c),
    .re(push), .raddr(addr), .rdata(old_q)
  );
  mkf_ram #(.WIDTH(8), .DEPTH(MAX_COLS)) u_newer (
    .clk(clk), .we(s1_v_r), .waddr(s1_addr_r), .wdata(s1_pix_r),
    .re(push), .raddr(addr), .rdata(new_q)
  );

  // Stage 1 pipeline register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= push;
    end
    if (push) begin
      s1_pix_r  <= pixel;
      s1_addr_r <= addr;
      s1_prod_r <= produce;
      s1_last_r <= frame_end;
    end
  end

  // A read of a column in the same cycle as its write returns the old
  // value; bypass covers the one-column frame.
  always_ff @(posedge clk) begin
    byp_r     <= push && s1_v_r && (s1_addr_r == addr);
    byp_old_r <= new_c;
    byp_new_r <= s1_pix_r;
  end
  assign old_c = byp_r ? byp_old_r : old_q;
  assign new_c = byp_r ? byp_new_r : new_q;

  // Window columns and the outgoing request. Entries 0..2 hold the column
  // two to the left (top, middle, bottom), entries 3..5 the column one left.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r    <= '0;
      out_v_r <= 1'b0;
    end else if (s1_v_r) begin
      wc_r    <= {s1_pix_r, new_c, old_c, wc_r[5], wc_r[4], wc_r[3]};
      out_v_r <= s1_prod_r;
    end else begin
      out_v_r <= 1'b0;
    end
    if (s1_v_r) begin
      out_r.pix  <= {wc_r[0], wc_r[3], old_c,
                     wc_r[1], wc_r[4], new_c,
                     wc_r[2], wc_r[5], s1_pix_r};
      out_r.last <= s1_last_r;
    end
  end

  assign req_valid = out_v_r && !stall;
  assign req       = out_r;
  assign busy      = s1_v_r || out_v_r;

endmodule

// ===== hdl/mkf_back.sv =====
// ----------------------------------------------------------------------------
// mkf_back: kernel arithmetic
// Two-stage pipeline: sums and gradients, then squares, divisions and clamps.
// ----------------------------------------------------------------------------
module mkf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_v,
  input  mkf_pkg::win_req_t win,
  output logic              res_v,
  output mkf_pkg::res_t     res
);

  logic signed [12:0] box, uns, low, gx, gy;
  logic signed [12:0] box_r, uns_r, low_r, gx_r, gy_r;
  logic signed [14:0] high, high_r;
  logic               last_r, v1_r, v2_r;
  logic        [10:0] ax, ay;
  logic        [22:0] mag;
  logic signed [14:0] boxq, highq, lowq;
  mkf_pkg::res_t      res_r;

  function automatic logic signed [12:0] px(input logic [7:0] p);
    px = $signed({5'd0, p});
  endfunction

  // The high-pass sum needs two more bits than the other kernels.
  function automatic logic signed [14:0] pw(input logic [7:0] p);
    pw = $signed({7'd0, p});
  endfunction

  function automatic logic [7:0] clamp(input logic signed [14:0] v);
    if (v < 0) clamp = 8'd0;
    else if (v > 15'sd255) clamp = 8'd255;
    else clamp = v[7:0];
  endfunction

  // Signed division by nine truncating toward zero, by reciprocal.
  function automatic logic signed [14:0] div9(input logic signed [14:0] v);
    logic [14:0] a;
    logic [26:0] p;
    logic [13:0] q;
    a = v[14] ? 15'(-v) : 15'(v);
    p = 27'(a) * 27'd3641;
    q = 14'(p >> 15);
    div9 = v[14] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  // Stage 1: kernel sums. Index 8 is top-left, 0 is bottom-right.
  always_comb begin
    box  = px(win.pix[8]) + px(win.pix[7]) + px(win.pix[6]) + px(win.pix[5])
         + px(win.pix[4]) + px(win.pix[3]) + px(win.pix[2]) + px(win.pix[1])
         + px(win.pix[0]);
    uns  = 13'sd5 * px(win.pix[4]) - px(win.pix[7]) - px(win.pix[5])
         - px(win.pix[3]) - px(win.pix[1]);
    high = 15'sd45 * pw(win.pix[4]) - 15'sd7 * (pw(win.pix[7]) + pw(win.pix[6])
         + pw(win.pix[2]) + pw(win.pix[1]));
    low  = 13'sd5 * px(win.pix[4]);
    gx   = (px(win.pix[6]) + 13'sd2 * px(win.pix[3]) + px(win.pix[0]))
         - (px(win.pix[8]) + 13'sd2 * px(win.pix[5]) + px(win.pix[2]));
    gy   = (px(win.pix[8]) + 13'sd2 * px(win.pix[7]) + px(win.pix[6]))
         - (px(win.pix[2]) + 13'sd2 * px(win.pix[1]) + px(win.pix[0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
    if (in_v) begin
      box_r <= box; uns_r <= uns; high_r <= high; low_r <= low;
      gx_r <= gx; gy_r <= gy; last_r <= win.last;
    end
  end

  // Stage 2: magnitude, divisions and clamps.
  always_comb begin
    ax    = gx_r[12] ? 11'(-gx_r) : 11'(gx_r);
    ay    = gy_r[12] ? 11'(-gy_r) : 11'(gy_r);
    mag   = (23'(ax) * 23'(ax) + 23'(ay) * 23'(ay)) >> 8;
    boxq  = div9(15'(box_r));
    highq = div9(high_r);
    lowq  = div9(15'(low_r));
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      res_r.box_value      <= clamp(boxq);
      res_r.sobel_value    <= (mag > 23'd255) ? 8'd255 : mag[7:0];
      res_r.unsharp_value  <= clamp(15'(uns_r));
      res_r.highpass_value <= clamp(highq);
      res_r.lowpass_value  <= clamp(lowq);
      res_r.last           <= last_r;
    end
  end

  assign res_v = v2_r;
  assign res   = res_r;

endmodule

// ===== hdl/mkf_fifo.sv =====
// ----------------------------------------------------------------------------
// mkf_fifo: small result queue
// Register-based FIFO holding finished results until popped.
// ----------------------------------------------------------------------------
module mkf_fifo #(
  parameter int DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  mkf_pkg::res_t wdata,
  input  logic          rd,
  output mkf_pkg::res_t rdata,
  output logic          empty,
  output logic [$clog2(DEPTH):0] count
);

  localparam int AW = $clog2(DEPTH);

  mkf_pkg::res_t   q_r [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + AW'(1);
      if (rd) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= wdata;
  end

  assign rdata = q_r[rp_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

endmodule

// ===== hdl/multi_kernel_3x3_image_filter.sv =====
// ----------------------------------------------------------------------------
// multi_kernel_3x3_image_filter: 3x3 box, Sobel, unsharp, high- and low-pass
// Streaming 3x3 filter over raster pixels with two line stores.
// ----------------------------------------------------------------------------
// Pixels are accepted one per clock while full is low; each pixel at row and
// column two or more yields one result with five filtered values. The rate
// of one pixel per cycle is set by the line stores, each read once and
// written once per pixel through separate ports. Results queue in an
// eight-entry FIFO; full rises when the queued results plus the pixels
// already in flight could fill that FIFO, so a stalled consumer stops the
// source.
module multi_kernel_3x3_image_filter #(
  parameter int MAX_COLS = mkf_pkg::MaxColsDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  in_luma,
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  out_box_value,
  output logic [7:0]                  out_sobel_value,
  output logic [7:0]                  out_unsharp_value,
  output logic [7:0]                  out_highpass_value,
  output logic [7:0]                  out_lowpass_value,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mkf_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [mkf_pkg::CfgDataW-1:0] cfg_data
);

  localparam int QDepth = 8;

  logic [11:0]       rows_r, cols_r;
  logic              pix_acc, front_busy, req_v, res_v, fifo_empty;
  logic              b1_r, b2_r;
  logic [$clog2(QDepth):0] cnt;
  logic [3:0]        inflight;
  mkf_pkg::win_req_t req;
  mkf_pkg::res_t     res, head;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= mkf_pkg::FRAME_ROWS_RESET;
      cols_r <= mkf_pkg::FRAME_COLS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        mkf_pkg::REG_FRAME_ROWS: rows_r <= cfg_data;
        mkf_pkg::REG_FRAME_COLS: cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Track pipeline occupancy to reserve queue room for in-flight pixels.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_r <= 1'b0;
      b2_r <= 1'b0;
    end else begin
      b1_r <= req_v;
      b2_r <= b1_r;
    end
  end
  assign inflight = 4'(front_busy) + 4'(front_busy) + 4'(b1_r) + 4'(b2_r);
  assign full    = (4'(cnt) + inflight) > 4'(QDepth - 1);
  assign pix_acc = push && !full;

  mkf_front #(.MAX_COLS(MAX_COLS)) u_front (
    .clk(clk), .rst_n(rst_n), .push(pix_acc), .pixel(in_luma),
    .frame_rows(rows_r), .frame_cols(cols_r), .stall(1'b0),
    .busy(front_busy), .req_valid(req_v), .req(req)
  );

  mkf_back u_back (
    .clk(clk), .rst_n(rst_n), .in_v(req_v), .win(req),
    .res_v(res_v), .res(res)
  );

  mkf_fifo #(.DEPTH(QDepth)) u_fifo (
    .clk(clk), .rst_n(rst_n), .wr(res_v), .wdata(res),
    .rd(pop && !fifo_empty), .rdata(head), .empty(fifo_empty), .count(cnt)
  );

  assign empty              = fifo_empty;
  assign out_box_value      = head.box_value;
  assign out_sobel_value    = head.sobel_value;
  assign out_unsharp_value  = head.unsharp_value;
  assign out_highpass_value = head.highpass_value;
  assign out_lowpass_value  = head.lowpass_value;
  assign out_last           = head.last;

  // The queue never overflows.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_v |-> (cnt < ($clog2(QDepth)+1)'(QDepth) || (pop && !fifo_empty)))
    else $error("result queue overflow");

  // A back-end result follows every front request through v1_r and v2_r.
  a_back_latency: assert property (@(posedge clk) disable iff (!rst_n)
    req_v |=> ##1 res_v)
    else $error("back end lost a request");

endmodule

// ===== test/tb_multi_kernel_3x3_image_filter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_kernel_3x3_image_filter: self-checking bench of the 3x3 filter
// Whole and partial frames are pushed through the filter under several frame
// sizes. A software line-store model predicts each filtered result, and every
// popped result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_multi_kernel_3x3_image_filter;

  localparam int MaxCols = 2048;
  localparam int DrainCycles = 24;
  localparam int CycleLimit = 600000;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_luma;
  logic        empty;
  logic        pop;
  logic [7:0]  out_box_value;
  logic [7:0]  out_sobel_value;
  logic [7:0]  out_unsharp_value;
  logic [7:0]  out_highpass_value;
  logic [7:0]  out_lowpass_value;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [mkf_pkg::CfgIdxW-1:0]  cfg_index;
  logic [mkf_pkg::CfgDataW-1:0] cfg_data;

  multi_kernel_3x3_image_filter i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_luma            (in_luma),
    .empty              (empty),
    .pop                (pop),
    .out_box_value      (out_box_value),
    .out_sobel_value    (out_sobel_value),
    .out_unsharp_value  (out_unsharp_value),
    .out_highpass_value (out_highpass_value),
    .out_lowpass_value  (out_lowpass_value),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Pixels waiting to be pushed and filtered results waiting to be popped.
  logic [7:0]    pixel_q[$];
  mkf_pkg::res_t filtered_q[$];
  int            error_count = 0;
  int            cycle_count = 0;
  bit            steady_flow = 0;

  // Model of the filter state.
  logic [7:0]  older_row[MaxCols];
  logic [7:0]  newer_row[MaxCols];
  logic [7:0]  win_cols[6];
  logic [11:0] row_pos;
  logic [10:0] col_pos;
  logic [11:0] rows_reg;
  logic [11:0] cols_reg;

  // Clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [7:0] clamp_byte(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Advance the model by one pixel; returns 1 when a result is produced.
  function automatic bit filter_pixel(logic [7:0] px, output mkf_pkg::res_t res);
    int rows, cols, col, i, j;
    int w[3][3];
    int gx, gy, c, box, unsharp, high;
    longint mag;
    bit row_end, frame_end, made;
    rows = (rows_reg == 0) ? 1 : rows_reg;
    cols = (cols_reg == 0) ? 1 : cols_reg;
    if (cols > MaxCols) cols = MaxCols;
    col = col_pos;
    made = 0;
    res = '0;
    w[0][2] = older_row[col];
    w[1][2] = newer_row[col];
    w[2][2] = px;
    for (i = 0; i < 3; i++) begin
      w[i][0] = win_cols[i];
      w[i][1] = win_cols[3 + i];
    end
    row_end = (col_pos + 1 >= cols);
    frame_end = row_end && (row_pos + 1 >= rows);
    if (row_pos >= 2 && col_pos >= 2) begin
      c = w[1][1];
      box = 0;
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) box += w[i][j];
      end
      unsharp = 5 * c - w[0][1] - w[1][0] - w[1][2] - w[2][1];
      high = 45 * c - 7 * (w[0][1] + w[0][2] + w[2][0] + w[2][1]);
      gx = (w[0][2] + 2 * w[1][2] + w[2][2]) - (w[0][0] + 2 * w[1][0] + w[2][0]);
      gy = (w[0][0] + 2 * w[0][1] + w[0][2]) - (w[2][0] + 2 * w[2][1] + w[2][2]);
      mag = (longint'(gx) * gx + longint'(gy) * gy) >>> 8;
      res.box_value      = clamp_byte(box / 9);
      res.sobel_value    = (mag > 255) ? 8'd255 : mag[7:0];
      res.unsharp_value  = clamp_byte(unsharp);
      res.highpass_value = clamp_byte(high / 9);
      res.lowpass_value  = clamp_byte((5 * c) / 9);
      res.last           = frame_end;
      made = 1;
    end
    older_row[col] = w[1][2][7:0];
    newer_row[col] = px;
    for (i = 0; i < 3; i++) begin
      win_cols[i] = w[i][1][7:0];
      win_cols[3 + i] = w[i][2][7:0];
    end
    if (frame_end) begin
      row_pos = '0;
      col_pos = '0;
    end else if (row_end) begin
      row_pos = row_pos + 1'b1;
      col_pos = '0;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return made;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Accept side: model every accepted pixel, check every popped result.
  always @(posedge clk) begin
    mkf_pkg::res_t r, e;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("multi_kernel_3x3_image_filter verification failed");
      $finish;
    end
    if (rst_n && push && !full) begin
      void'(pixel_q.pop_front());
      if (filter_pixel(in_luma, r)) filtered_q.push_back(r);
    end
    if (rst_n && pop && !empty) begin
      if (filtered_q.size() == 0) begin
        $error("result popped with no result predicted");
        error_count++;
      end else begin
        e = filtered_q.pop_front();
        check_field("box_value", e.box_value, out_box_value);
        check_field("sobel_value", e.sobel_value, out_sobel_value);
        check_field("unsharp_value", e.unsharp_value, out_unsharp_value);
        check_field("highpass_value", e.highpass_value, out_highpass_value);
        check_field("lowpass_value", e.lowpass_value, out_lowpass_value);
        check_field("last", e.last, out_last);
      end
    end
  end

  // Pixel driver and result consumer idle at random unless steady_flow is set.
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      pop <= 1'b0;
    end else begin
      if (pixel_q.size() != 0 && (steady_flow || $urandom_range(99) >= 23)) begin
        push <= 1'b1;
        in_luma <= pixel_q[0];
      end else begin
        push <= 1'b0;
      end
      pop <= steady_flow || ($urandom_range(99) >= 23);
    end
  end

  task automatic write_reg(logic [mkf_pkg::CfgIdxW-1:0] idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[11:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == mkf_pkg::REG_FRAME_ROWS) rows_reg = value[11:0];
    else cols_reg = value[11:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every pixel is in and every result is out, then let the
  // pipeline drain pixels that make no result.
  task automatic settle();
    while (pixel_q.size() != 0 || filtered_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Queue n pixels of one pattern: random, flat maximum, alternating
  // 0 and 255, random extremes.
  task automatic queue_pixels(int n, int pattern);
    int k;
    for (k = 0; k < n; k++) begin
      case (pattern)
        1: pixel_q.push_back(8'hFF);
        2: pixel_q.push_back((k % 2) ? 8'hFF : 8'h00);
        3: pixel_q.push_back($urandom_range(1) ? 8'hFF : 8'h00);
        default: pixel_q.push_back(8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic run_frames(int rows, int cols, int frames, int pattern);
    int r, c;
    write_reg(mkf_pkg::REG_FRAME_ROWS, rows);
    write_reg(mkf_pkg::REG_FRAME_COLS, cols);
    r = (rows == 0) ? 1 : rows;
    c = (cols == 0) ? 1 : ((cols > MaxCols) ? MaxCols : cols);
    queue_pixels(r * c * frames, pattern);
    settle();
  endtask

  initial begin
    int sent, rows, cols, frames, pat;
    rst_n = 1'b0;
    push = 1'b0;
    in_luma = '0;
    pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rows_reg = mkf_pkg::FRAME_ROWS_RESET;
    cols_reg = mkf_pkg::FRAME_COLS_RESET;
    row_pos = '0;
    col_pos = '0;
    foreach (win_cols[i]) win_cols[i] = '0;
    for (int i = 0; i < MaxCols; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: smallest frame with output, flat white, stripes, random extremes.
    run_frames(3, 3, 1, 1);
    run_frames(3, 4, 1, 2);
    run_frames(3, 3, 1, 3);
    // Zero sizes act as one: frames too small for any result.
    run_frames(0, 5, 1, 0);
    run_frames(4, 0, 1, 0);
    run_frames(2, 2, 1, 3);

    // Frame size changed in the middle of a frame: two clean frames fill the
    // line stores, then the width shrinks while at row two, column three.
    run_frames(5, 6, 2, 0);
    queue_pixels(15, 0);
    settle();
    write_reg(mkf_pkg::REG_FRAME_COLS, 4);
    queue_pixels(9, 0);
    settle();

    // Extremes of both registers: the tallest frame is cut short by lowering
    // the row count, the widest row by lowering the column count.
    write_reg(mkf_pkg::REG_FRAME_ROWS, 4095);
    write_reg(mkf_pkg::REG_FRAME_COLS, 3);
    queue_pixels(15, 0);
    settle();
    write_reg(mkf_pkg::REG_FRAME_ROWS, 3);
    queue_pixels(3, 3);
    settle();
    write_reg(mkf_pkg::REG_FRAME_COLS, 4095);
    queue_pixels(10, 0);
    settle();
    write_reg(mkf_pkg::REG_FRAME_COLS, 5);
    queue_pixels(11, 0);
    settle();

    // Random frames, mostly small, one stretch with no idling.
    sent = 0;
    while (sent < 730) begin
      steady_flow = (sent >= 250 && sent < 400);
      rows = $urandom_range(1, 7);
      cols = ($urandom_range(19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 9);
      frames = $urandom_range(1, 3);
      pat = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
      run_frames(rows, cols, frames, pat);
      sent += rows * cols * frames;
    end
    steady_flow = 0;
    settle();

    if (error_count == 0) begin
      $display("multi_kernel_3x3_image_filter verification clean");
    end else begin
      $display("multi_kernel_3x3_image_filter verification failed");
    end
    $finish;
  end

endmodule
